/* rtl/butterworth_lowpass_biquad_macros.svh */
// assertion macros for the butterworth low-pass biquad checker
// no dependencies; included by the checker file
`ifndef BUTTERWORTH_LOWPASS_BIQUAD_MACROS_SVH
`define BUTTERWORTH_LOWPASS_BIQUAD_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define BWLP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

// consequent must hold a fixed number of cycles after the antecedent
`define BWLP_ASSERT_LATER(lbl, clk, rstn, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

/* rtl/bwlp_pkg.sv */
// shared constants, types, saturation helpers and control store of the biquad
// no dependencies
package bwlp_pkg;

  // field and datapath widths
  localparam int SAMPLE_W  = 16;
  localparam int HIST_W    = 24;
  localparam int COEF_W    = 18;
  localparam int SCALE_W   = 16;
  localparam int GAIN_W    = 16;
  localparam int PROD_W    = HIST_W + COEF_W;
  localparam int ACC_W     = 46;
  localparam int STEP_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 18;

  // binary point alignment
  localparam int IN_SHIFT  = 8;
  localparam int FB_SHIFT  = 16;
  localparam int OUT_SHIFT = 20;
  localparam logic signed [ACC_W-1:0] RND_IN  = ACC_W'(1) <<< (IN_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] RND_FB  = ACC_W'(1) <<< (FB_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] RND_OUT = ACC_W'(1) <<< (OUT_SHIFT - 1);

  // saturation limits
  localparam logic [HIST_W-1:0]   HIST_MAX   = {1'b0, {(HIST_W-1){1'b1}}};
  localparam logic [HIST_W-1:0]   HIST_MIN   = {1'b1, {(HIST_W-1){1'b0}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_ONE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_TWO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN  = 2'd3;

  // register reset values
  localparam logic [SCALE_W-1:0]        SCALE_RST = 16'd6398;
  localparam logic signed [COEF_W-1:0]  FB1_RST   = -18'sd61788;
  localparam logic signed [COEF_W-1:0]  FB2_RST   = 18'sd21845;
  localparam logic [GAIN_W-1:0]         GAIN_RST  = 16'd8192;

  // program step addresses
  localparam logic [STEP_W-1:0] ST_WAIT  = 3'd0;
  localparam logic [STEP_W-1:0] ST_SCALE = 3'd1;
  localparam logic [STEP_W-1:0] ST_SUM   = 3'd2;
  localparam logic [STEP_W-1:0] ST_SUB   = 3'd3;
  localparam logic [STEP_W-1:0] ST_STORE = 3'd4;
  localparam logic [STEP_W-1:0] ST_GAIN  = 3'd5;
  localparam logic [STEP_W-1:0] ST_OUT   = 3'd6;

  // multiplier operand selects
  typedef enum logic [1:0] {MA_SAMPLE, MA_Y1, MA_Y0, MA_Y} mul_a_e;
  typedef enum logic [1:0] {MB_SCALE, MB_FB1, MB_FB2, MB_GAIN} mul_b_e;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NONE, OP_SCALE_IN, OP_SUM_START, OP_SUM_SUB, OP_STORE_Y, OP_OUTPUT
  } alu_op_e;

  // jump conditions: the jump is taken while the condition holds
  typedef enum logic [1:0] {JC_NONE, JC_NO_INPUT, JC_OUT_BUSY} jump_e;

  typedef struct packed {
    logic               mul_en;
    mul_a_e             mul_a;
    mul_b_e             mul_b;
    alu_op_e            op;
    jump_e              jump;
    logic [STEP_W-1:0]  jump_to;
    logic               last;
  } ucode_t;

  typedef struct packed {
    logic [HIST_W-1:0] val;
    logic              clip;
  } sat_hist_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] val;
    logic                clip;
  } sat_sample_t;

  localparam ucode_t UC_NOP = '{
    mul_en: 1'b0, mul_a: MA_SAMPLE, mul_b: MB_SCALE, op: OP_NONE,
    jump: JC_NONE, jump_to: ST_WAIT, last: 1'b0
  };

  // control store
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = UC_NOP;
    unique case (step)
      ST_WAIT: begin
        w.mul_en  = 1'b1;
        w.mul_a   = MA_SAMPLE;
        w.mul_b   = MB_SCALE;
        w.jump    = JC_NO_INPUT;
        w.jump_to = ST_WAIT;
      end
      ST_SCALE: begin
        w.mul_en = 1'b1;
        w.mul_a  = MA_Y1;
        w.mul_b  = MB_FB1;
        w.op     = OP_SCALE_IN;
      end
      ST_SUM: begin
        w.mul_en = 1'b1;
        w.mul_a  = MA_Y0;
        w.mul_b  = MB_FB2;
        w.op     = OP_SUM_START;
      end
      ST_SUB: begin
        w.op = OP_SUM_SUB;
      end
      ST_STORE: begin
        w.op = OP_STORE_Y;
      end
      ST_GAIN: begin
        w.mul_en = 1'b1;
        w.mul_a  = MA_Y;
        w.mul_b  = MB_GAIN;
      end
      ST_OUT: begin
        w.op      = OP_OUTPUT;
        w.jump    = JC_OUT_BUSY;
        w.jump_to = ST_OUT;
        w.last    = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

  // clamp a wide value to the history width
  function automatic sat_hist_t sat_hist(input logic signed [ACC_W-1:0] v);
    sat_hist_t r;
    logic [ACC_W-HIST_W:0] top;
    top = v[ACC_W-1:HIST_W-1];
    if ((&top) || !(|top)) begin
      r.val  = v[HIST_W-1:0];
      r.clip = 1'b0;
    end else begin
      r.val  = v[ACC_W-1] ? HIST_MIN : HIST_MAX;
      r.clip = 1'b1;
    end
    return r;
  endfunction

  // clamp a wide value to the sample width
  function automatic sat_sample_t sat_sample(input logic signed [ACC_W-1:0] v);
    sat_sample_t r;
    logic [ACC_W-SAMPLE_W:0] top;
    top = v[ACC_W-1:SAMPLE_W-1];
    if ((&top) || !(|top)) begin
      r.val  = v[SAMPLE_W-1:0];
      r.clip = 1'b0;
    end else begin
      r.val  = v[ACC_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
      r.clip = 1'b1;
    end
    return r;
  endfunction

endpackage

/* rtl/bwlp_stream_if.sv */
// valid/ready stream interfaces for the biquad sample input and result output
// depends on bwlp_pkg
interface bwlp_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bwlp_pkg::SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface bwlp_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bwlp_pkg::SAMPLE_W-1:0] sample_out;
  logic                                 clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

/* rtl/butterworth_lowpass_biquad.sv */
// second-order butterworth low-pass stage, fixed taps 1,2,1, output gain
// a seven-step microprogram drives one shared 24x18 multiplier and accumulator
// result registered in the out step, after steps scale, sum, sub, store, gain
// input taken only in the wait step; the out step stalls while output is held
// reset: async active low, coefficients to defaults, history cleared
// depends on bwlp_pkg and bwlp_stream_if
module butterworth_lowpass_biquad (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bwlp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bwlp_pkg::CFG_DAT_W-1:0]     cfg_data_i,
  bwlp_in_if.sink                            in_chan_i,
  bwlp_out_if.source                         out_chan_o
);
  import bwlp_pkg::*;

  // configuration registers
  logic [SCALE_W-1:0]        scale_q;
  logic signed [COEF_W-1:0]  fb1_q;
  logic signed [COEF_W-1:0]  fb2_q;
  logic [GAIN_W-1:0]         gain_q;

  // sequencer
  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            uw;
  logic              in_acc;
  logic              out_free;
  logic              jump_taken;

  // datapath
  logic signed [HIST_W-1:0] mul_a;
  logic signed [COEF_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  prod_ext, x_ext, ih0_ext, ih1_ext, taps;
  logic signed [ACC_W-1:0]  x_rnd, y_rnd, o_rnd;
  logic signed [HIST_W-1:0] x_q, y_q;
  logic signed [HIST_W-1:0] ih0_q, ih1_q, oh0_q, oh1_q;
  logic                     clip_q;
  sat_hist_t                x_sat, y_sat;
  sat_sample_t              o_sat;

  // output register
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_sample_q;
  logic                out_clip_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RST;
      fb1_q   <= FB1_RST;
      fb2_q   <= FB2_RST;
      gain_q  <= GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INPUT_SCALE:  scale_q <= cfg_data_i[SCALE_W-1:0];
        CFG_FEEDBACK_ONE: fb1_q   <= cfg_data_i[COEF_W-1:0];
        CFG_FEEDBACK_TWO: fb2_q   <= cfg_data_i[COEF_W-1:0];
        CFG_OUTPUT_GAIN:  gain_q  <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // control word fetch and handshakes
  assign uw              = ucode_rom(step_q);
  assign in_chan_i.ready = (uw.jump == JC_NO_INPUT);
  assign in_acc          = in_chan_i.valid && in_chan_i.ready;
  assign out_free        = !out_valid_q || out_chan_o.ready;

  // step counter with conditional jump
  always_comb begin
    case (uw.jump)
      JC_NO_INPUT: jump_taken = !in_acc;
      JC_OUT_BUSY: jump_taken = !out_free;
      default:     jump_taken = 1'b0;
    endcase
    if (jump_taken) begin
      step_d = uw.jump_to;
    end else if (uw.last) begin
      step_d = ST_WAIT;
    end else begin
      step_d = step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  // multiplier operand selection
  always_comb begin
    case (uw.mul_a)
      MA_SAMPLE: mul_a = {{(HIST_W-SAMPLE_W){in_chan_i.sample_in[SAMPLE_W-1]}},
                          in_chan_i.sample_in};
      MA_Y1:     mul_a = oh0_q;
      MA_Y0:     mul_a = oh1_q;
      default:   mul_a = y_q;
    endcase
    case (uw.mul_b)
      MB_SCALE: mul_b = {{(COEF_W-SCALE_W){1'b0}}, scale_q};
      MB_FB1:   mul_b = fb1_q;
      MB_FB2:   mul_b = fb2_q;
      default:  mul_b = {{(COEF_W-GAIN_W){1'b0}}, gain_q};
    endcase
  end

  // registered product
  always_ff @(posedge clk_i) begin
    if (uw.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
  end

  // rounding, tap sum and saturation
  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign x_ext    = {{(ACC_W-HIST_W){x_q[HIST_W-1]}}, x_q};
  assign ih0_ext  = {{(ACC_W-HIST_W){ih0_q[HIST_W-1]}}, ih0_q};
  assign ih1_ext  = {{(ACC_W-HIST_W){ih1_q[HIST_W-1]}}, ih1_q};
  assign taps     = x_ext + (ih0_ext <<< 1) + ih1_ext;
  assign x_rnd    = (prod_ext + RND_IN) >>> IN_SHIFT;
  assign y_rnd    = acc_q >>> FB_SHIFT;
  assign o_rnd    = (prod_ext + RND_OUT) >>> OUT_SHIFT;
  assign x_sat    = sat_hist(x_rnd);
  assign y_sat    = sat_hist(y_rnd);
  assign o_sat    = sat_sample(o_rnd);

  // accumulator next value
  always_comb begin
    case (uw.op)
      OP_SUM_START: acc_d = (taps <<< FB_SHIFT) - prod_ext + RND_FB;
      OP_SUM_SUB:   acc_d = acc_q - prod_ext;
      default:      acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (uw.op == OP_SCALE_IN) begin
      x_q <= x_sat.val;
    end
    if (uw.op == OP_STORE_Y) begin
      y_q <= y_sat.val;
    end
  end

  // filter history and clip flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ih0_q  <= '0;
      ih1_q  <= '0;
      oh0_q  <= '0;
      oh1_q  <= '0;
      clip_q <= 1'b0;
    end else begin
      if (uw.op == OP_SCALE_IN) begin
        clip_q <= x_sat.clip;
      end
      if (uw.op == OP_STORE_Y) begin
        ih1_q  <= ih0_q;
        ih0_q  <= x_q;
        oh1_q  <= oh0_q;
        oh0_q  <= y_sat.val;
        clip_q <= clip_q | y_sat.clip;
      end
    end
  end

  // output register, loaded on the last step once it is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (uw.op == OP_OUTPUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_chan_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uw.op == OP_OUTPUT && out_free) begin
      out_sample_q <= o_sat.val;
      out_clip_q   <= clip_q | o_sat.clip;
    end
  end

  assign out_chan_o.valid      = out_valid_q;
  assign out_chan_o.sample_out = out_sample_q;
  assign out_chan_o.clipped    = out_clip_q;

endmodule

/* rtl/bwlp_checker.sv */
// port-level checks for the biquad: output handshake and program occupancy
// depends on bwlp_pkg and the assertion macro header; bound to the top level
`include "butterworth_lowpass_biquad_macros.svh"

module bwlp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [bwlp_pkg::SAMPLE_W-1:0] sample_out_i,
  input logic                          clipped_i
);
  import bwlp_pkg::*;

  logic in_xfer;
  logic out_stall;

  assign in_xfer   = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  // a stalled result stays offered
  `BWLP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i, "result dropped while stalled")

  // a stalled result keeps its payload
  `BWLP_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_stall, $stable(sample_out_i) && $stable(clipped_i), "result changed while stalled")

  // one sample in flight: no new transfer right after one
  `BWLP_ASSERT_NEXT(a_busy_next, clk_i, rst_ni, in_xfer, !in_ready_i, "input taken during processing")

  // the program still runs, input not ready, up to its output step after a transfer
  `BWLP_ASSERT_LATER(a_busy_late, clk_i, rst_ni, in_xfer, 6, !in_ready_i, "input taken before program end")

endmodule

bind butterworth_lowpass_biquad bwlp_checker u_bwlp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_chan_i.valid),
  .in_ready_i   (in_chan_i.ready),
  .out_valid_i  (out_chan_o.valid),
  .out_ready_i  (out_chan_o.ready),
  .sample_out_i (out_chan_o.sample_out),
  .clipped_i    (out_chan_o.clipped)
);
